>>> sv/gnpe_pkg.sv
// package: shared constants, types and the divider step for the gradient noise core
package gnpe_pkg;

  localparam int GRAD_DEPTH    = 1024;
  localparam int COORD_BITS    = 12;
  localparam int GRADIENT_BITS = 8;

  localparam int GRAD_AW     = $clog2(GRAD_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int QUO_BITS    = COORD_BITS + FRAC_BITS;
  localparam int CELL_BITS   = 9;
  localparam int STRIDE_BITS = 11;
  localparam int OUT_BITS    = 26;
  localparam int INDEX_BITS  = 10;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  // offsets are signed Q.16 values in [-65535, 65536]
  localparam int OFF_W  = FRAC_BITS + 2;
  localparam int PROD_W = OFF_W + GRADIENT_BITS;
  localparam int DOT_W  = PROD_W + 1;
  localparam int DIF_W  = DOT_W + 1;
  localparam int MUL0_W = DIF_W + FRAC_BITS + 1;
  localparam int LERP_W = DOT_W + 2;
  localparam int DL_W   = LERP_W + 1;
  localparam int MUL1_W = DL_W + FRAC_BITS + 1;

  localparam logic [CELL_BITS-1:0]   CELL_SIZE_RESET  = CELL_BITS'(16);
  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET = STRIDE_BITS'(34);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_SIZE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STRIDE = CFG_IDX_BITS'(1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

  // load fields that ride alongside the division
  typedef struct packed {
    action_t                         action;
    logic [INDEX_BITS-1:0]           gidx;
    logic signed [GRADIENT_BITS-1:0] gx;
    logic signed [GRADIENT_BITS-1:0] gy;
  } side_t;

  // one lane of the restoring divider: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [CELL_BITS-1:0] rem;
    logic [QUO_BITS-1:0]  qd;
  } div_lane_t;

  // one restoring division step, one quotient bit shifted in at the bottom
  function automatic div_lane_t div_step(input div_lane_t a, input logic [CELL_BITS-1:0] s);
    logic [CELL_BITS:0] trial;
    div_lane_t          r;
    trial = {a.rem, a.qd[QUO_BITS-1]};
    r.qd  = {a.qd[QUO_BITS-2:0], 1'b0};
    if (trial >= {1'b0, s}) begin
      r.rem   = CELL_BITS'(trial - {1'b0, s});
      r.qd[0] = 1'b1;
    end else begin
      r.rem = trial[CELL_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/gradient_noise_pixel_eval_core.sv
// top level: 2d gradient noise evaluation pipeline with gradient table
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       tuser action, tdata load and pixel fields
// m_*      out  m_tvalid / m_tready       tdata noise_value
// cfg_*    in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one word accepted per cycle while no output word waits; an evaluate word
// passes 28 divider stages for the cell and fraction, then 11 stages of
// address, table read, dot products and the two interpolations
// load words write the table in the read stage and give no output word
// rst clears all valid bits and the config registers; the table is undefined until loaded
// the whole pipeline holds while the output word waits, nothing is lost or repeated
module gradient_noise_pixel_eval_core
  import gnpe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [55:0]              s_tdata,   // gradient_index, gradient_x, gradient_y, pixel_x, pixel_y
  input  logic                     s_tuser,   // action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [31:0]              m_tdata,   // noise_value
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic                   en;
  logic [CELL_BITS-1:0]   cell_size;
  logic [STRIDE_BITS-1:0] row_stride;
  logic [CELL_BITS-1:0]   divisor;
  side_t                  in_side;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size  <= CELL_SIZE_RESET;
      row_stride <= ROW_STRIDE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CELL_SIZE:  cell_size  <= cfg_data[CELL_BITS-1:0];
        CFG_ROW_STRIDE: row_stride <= cfg_data[STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign divisor = (cell_size == '0) ? CELL_BITS'(1) : cell_size;

  // input unpacking
  always_comb begin
    in_side.action = action_t'(s_tuser);
    in_side.gidx   = s_tdata[9:0];
    in_side.gx     = s_tdata[17:10];
    in_side.gy     = s_tdata[25:18];
  end

  logic                  dv_vld;
  side_t                 dv_side;
  logic [COORD_BITS-1:0] dv_cx;
  logic [COORD_BITS-1:0] dv_cy;
  logic [FRAC_BITS-1:0]  dv_u;
  logic [FRAC_BITS-1:0]  dv_v;

  gnpe_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_tvalid && s_tready),
    .in_side  (in_side),
    .in_x     (s_tdata[37:26]),
    .in_y     (s_tdata[49:38]),
    .divisor  (divisor),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .cx       (dv_cx),
    .cy       (dv_cy),
    .u        (dv_u),
    .v        (dv_v)
  );

  // valid bits of the stages after the divider
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld, h_vld, i_vld, j_vld;
  action_t a_act, b_act, c_act, d_act, e_act, f_act, g_act, h_act, i_act, j_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; d_vld <= 1'b0; e_vld <= 1'b0;
      f_vld <= 1'b0; g_vld <= 1'b0; h_vld <= 1'b0; i_vld <= 1'b0; j_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      a_vld <= dv_vld; b_vld <= a_vld; c_vld <= b_vld; d_vld <= c_vld; e_vld <= d_vld;
      f_vld <= e_vld; g_vld <= f_vld; h_vld <= g_vld; i_vld <= h_vld; j_vld <= i_vld;
      m_tvalid <= j_vld && (j_act == ACT_EVAL);
    end
  end

  // stage a: row base of the cell, modulo the table depth
  side_t                                a_side;
  logic [GRAD_AW-1:0]                   a_cx;
  logic [GRAD_AW-1:0]                   a_row;
  logic [FRAC_BITS-1:0]                 a_u, a_v;
  logic [COORD_BITS+STRIDE_BITS-1:0]    row_full;

  assign row_full = dv_cy * row_stride;

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= dv_side;
      a_act  <= dv_side.action;
      a_cx   <= GRAD_AW'(dv_cx);
      a_row  <= row_full[GRAD_AW-1:0];
      a_u    <= dv_u;
      a_v    <= dv_v;
    end
  end

  // stage b: four corner addresses
  side_t                b_side;
  logic [GRAD_AW-1:0]   b_a00, b_a10, b_a01, b_a11;
  logic [FRAC_BITS-1:0] b_u, b_v;
  logic [GRAD_AW-1:0]   base, base_dn;

  assign base    = a_cx + a_row;
  assign base_dn = base + GRAD_AW'(row_stride);

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      b_act  <= a_act;
      b_a00  <= base;
      b_a10  <= base + GRAD_AW'(1);
      b_a01  <= base_dn;
      b_a11  <= base_dn + GRAD_AW'(1);
      b_u    <= a_u;
      b_v    <= a_v;
    end
  end

  // stage c: gradient table, two copies with two read ports each
  logic [2*GRADIENT_BITS-1:0] grad_top_mem [GRAD_DEPTH];
  logic [2*GRADIENT_BITS-1:0] grad_bot_mem [GRAD_DEPTH];
  logic [2*GRADIENT_BITS-1:0] c_g00, c_g10, c_g01, c_g11;
  logic [FRAC_BITS-1:0]       c_u, c_v;
  logic                       we;
  logic [GRAD_AW-1:0]         waddr;

  assign we    = en && b_vld && (b_act == ACT_LOAD);
  assign waddr = GRAD_AW'(b_side.gidx);

  always_ff @(posedge clk) begin
    if (we) begin
      grad_top_mem[waddr] <= {b_side.gx, b_side.gy};
      grad_bot_mem[waddr] <= {b_side.gx, b_side.gy};
    end
    if (en) begin
      c_g00 <= grad_top_mem[b_a00];
      c_g10 <= grad_top_mem[b_a10];
      c_g01 <= grad_bot_mem[b_a01];
      c_g11 <= grad_bot_mem[b_a11];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_act <= b_act;
      c_u   <= b_u;
      c_v   <= b_v;
    end
  end

  // stage d: eight offset by gradient products
  logic signed [OFF_W-1:0]  neg_u, pos_u, neg_v, pos_v;
  logic signed [PROD_W-1:0] d_px00, d_py00, d_px10, d_py10, d_px01, d_py01, d_px11, d_py11;
  logic [FRAC_BITS-1:0]     d_u, d_v;

  assign neg_u = -$signed({2'b00, c_u});
  assign pos_u = $signed(OFF_W'(1) << FRAC_BITS) + neg_u;
  assign neg_v = -$signed({2'b00, c_v});
  assign pos_v = $signed(OFF_W'(1) << FRAC_BITS) + neg_v;

  always_ff @(posedge clk) begin
    if (en) begin
      d_act  <= c_act;
      d_u    <= c_u;
      d_v    <= c_v;
      d_px00 <= neg_u * $signed(c_g00[2*GRADIENT_BITS-1:GRADIENT_BITS]);
      d_py00 <= neg_v * $signed(c_g00[GRADIENT_BITS-1:0]);
      d_px10 <= pos_u * $signed(c_g10[2*GRADIENT_BITS-1:GRADIENT_BITS]);
      d_py10 <= neg_v * $signed(c_g10[GRADIENT_BITS-1:0]);
      d_px01 <= neg_u * $signed(c_g01[2*GRADIENT_BITS-1:GRADIENT_BITS]);
      d_py01 <= pos_v * $signed(c_g01[GRADIENT_BITS-1:0]);
      d_px11 <= pos_u * $signed(c_g11[2*GRADIENT_BITS-1:GRADIENT_BITS]);
      d_py11 <= pos_v * $signed(c_g11[GRADIENT_BITS-1:0]);
    end
  end

  // stage e: corner dot products
  logic signed [DOT_W-1:0] e_d00, e_d10, e_d01, e_d11;
  logic [FRAC_BITS-1:0]    e_u, e_v;

  always_ff @(posedge clk) begin
    if (en) begin
      e_act <= d_act;
      e_u   <= d_u;
      e_v   <= d_v;
      e_d00 <= DOT_W'(d_px00) + DOT_W'(d_py00);
      e_d10 <= DOT_W'(d_px10) + DOT_W'(d_py10);
      e_d01 <= DOT_W'(d_px01) + DOT_W'(d_py01);
      e_d11 <= DOT_W'(d_px11) + DOT_W'(d_py11);
    end
  end

  // stage f: x differences
  logic signed [DIF_W-1:0] f_dif0, f_dif1;
  logic signed [DOT_W-1:0] f_d00, f_d01;
  logic [FRAC_BITS-1:0]    f_u, f_v;

  always_ff @(posedge clk) begin
    if (en) begin
      f_act  <= e_act;
      f_u    <= e_u;
      f_v    <= e_v;
      f_d00  <= e_d00;
      f_d01  <= e_d01;
      f_dif0 <= DIF_W'(e_d10) - DIF_W'(e_d00);
      f_dif1 <= DIF_W'(e_d11) - DIF_W'(e_d01);
    end
  end

  // stage g: scale x differences by u
  logic signed [MUL0_W-1:0] g_m0, g_m1;
  logic signed [DOT_W-1:0]  g_d00, g_d01;
  logic [FRAC_BITS-1:0]     g_v;

  always_ff @(posedge clk) begin
    if (en) begin
      g_act <= f_act;
      g_v   <= f_v;
      g_d00 <= f_d00;
      g_d01 <= f_d01;
      g_m0  <= f_dif0 * $signed({1'b0, f_u});
      g_m1  <= f_dif1 * $signed({1'b0, f_u});
    end
  end

  // stage h: x interpolation, arithmetic shift floors toward minus infinity
  logic signed [LERP_W-1:0] h_l0, h_l1;
  logic [FRAC_BITS-1:0]     h_v;
  logic signed [MUL0_W-1:0] sh0, sh1;

  assign sh0 = g_m0 >>> FRAC_BITS;
  assign sh1 = g_m1 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      h_act <= g_act;
      h_v   <= g_v;
      h_l0  <= LERP_W'(g_d00) + LERP_W'(sh0);
      h_l1  <= LERP_W'(g_d01) + LERP_W'(sh1);
    end
  end

  // stage i: y difference
  logic signed [DL_W-1:0]   i_dl;
  logic signed [LERP_W-1:0] i_l0;
  logic [FRAC_BITS-1:0]     i_v;

  always_ff @(posedge clk) begin
    if (en) begin
      i_act <= h_act;
      i_v   <= h_v;
      i_l0  <= h_l0;
      i_dl  <= DL_W'(h_l1) - DL_W'(h_l0);
    end
  end

  // stage j: scale y difference by v
  logic signed [MUL1_W-1:0] j_m;
  logic signed [LERP_W-1:0] j_l0;

  always_ff @(posedge clk) begin
    if (en) begin
      j_act <= i_act;
      j_l0  <= i_l0;
      j_m   <= i_dl * $signed({1'b0, i_v});
    end
  end

  // output register: y interpolation
  logic signed [MUL1_W-1:0] shy;
  logic signed [LERP_W-1:0] noise;

  assign shy   = j_m >>> FRAC_BITS;
  assign noise = j_l0 + LERP_W'(shy);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {{(32-OUT_BITS){1'b0}}, noise[OUT_BITS-1:0]};
    end
  end

  // a waiting output word freezes the input side
  assert property (@(posedge clk) disable iff (rst) m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output word stalled");

  // no output word right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // table writes only happen while the pipeline moves
  assert property (@(posedge clk) disable iff (rst) we |-> (!m_tvalid || m_tready))
    else $error("table written during a stall");

endmodule

>>> sv/gnpe_div_pipe.sv
// pipelined restoring divider: (coord << 16) / cell size for x and y, one bit per stage
module gnpe_div_pipe
  import gnpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  side_t                 in_side,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic [CELL_BITS-1:0]  divisor,
  output logic                  out_vld,
  output side_t                 out_side,
  output logic [COORD_BITS-1:0] cx,
  output logic [COORD_BITS-1:0] cy,
  output logic [FRAC_BITS-1:0]  u,
  output logic [FRAC_BITS-1:0]  v
);

  logic      vld [QUO_BITS];
  side_t     sd  [QUO_BITS];
  div_lane_t xl  [QUO_BITS];
  div_lane_t yl  [QUO_BITS];
  div_lane_t x0;
  div_lane_t y0;

  // first lane word: zero remainder, coordinate followed by fraction zeros
  always_comb begin
    x0.rem = '0;
    x0.qd  = {in_x, {FRAC_BITS{1'b0}}};
    y0.rem = '0;
    y0.qd  = {in_y, {FRAC_BITS{1'b0}}};
  end

  // valid bits per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_BITS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 1; k < QUO_BITS; k++) vld[k] <= vld[k-1];
    end
  end

  // division stages
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= in_side;
      xl[0] <= div_step(x0, divisor);
      yl[0] <= div_step(y0, divisor);
      for (int k = 1; k < QUO_BITS; k++) begin
        sd[k] <= sd[k-1];
        xl[k] <= div_step(xl[k-1], divisor);
        yl[k] <= div_step(yl[k-1], divisor);
      end
    end
  end

  assign out_vld  = vld[QUO_BITS-1];
  assign out_side = sd[QUO_BITS-1];
  assign cx       = xl[QUO_BITS-1].qd[QUO_BITS-1:FRAC_BITS];
  assign cy       = yl[QUO_BITS-1].qd[QUO_BITS-1:FRAC_BITS];
  assign u        = xl[QUO_BITS-1].qd[FRAC_BITS-1:0];
  assign v        = yl[QUO_BITS-1].qd[FRAC_BITS-1:0];

endmodule
